@@ hw/rtl/mu8d_pkg.sv @@
// ----------------------------------------------------------------------------
// mu8d_pkg
// Shared types for the modified UTF-8 string decoder: phase codes and the
// result record passed from the decode stage to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package mu8d_pkg;

    // Decode phase, one-hot
    typedef enum logic [6:0] {
        PH_LEN_HI   = 7'b000_0001,
        PH_LEN_LO   = 7'b000_0010,
        PH_LEAD     = 7'b000_0100,
        PH_TWO_B2   = 7'b000_1000,
        PH_THREE_B2 = 7'b001_0000,
        PH_THREE_B3 = 7'b010_0000,
        PH_DISCARD  = 7'b100_0000
    } phase_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        has_unit;
        logic        last;
        logic        malformed;
    } result_t;

    localparam logic [15:0] MIN_TWO_BYTE   = 16'h0080;
    localparam logic [15:0] MIN_THREE_BYTE = 16'h0800;

endpackage

`default_nettype wire

@@ hw/rtl/mu8d_decode.sv @@
// ----------------------------------------------------------------------------
// mu8d_decode
// Per-byte decode step: string state registers and the next-state and
// result logic for one body or length byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mu8d_decode
    import mu8d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    output logic            res_valid,
    output result_t         res
);

    phase_t      phase_reg,        phase_next;
    logic [7:0]  length_high_reg,  length_high_next;
    logic [15:0] bytes_left_reg,   bytes_left_next;
    logic [15:0] partial_unit_reg, partial_unit_next;

    logic [15:0] bl_dec;
    logic        at_end;
    logic [15:0] unit_value;
    phase_t      fail_phase;
    phase_t      unit_phase;
    logic        cont_ok;
    result_t     fail_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LEN_HI;
            length_high_reg  <= '0;
            bytes_left_reg   <= '0;
            partial_unit_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            length_high_reg  <= length_high_next;
            bytes_left_reg   <= bytes_left_next;
            partial_unit_reg <= partial_unit_next;
        end
    end

    always_comb
    begin
        bl_dec     = bytes_left_reg - 16'd1;
        at_end     = (bl_dec == 16'd0);
        fail_phase = at_end ? PH_LEN_HI : PH_DISCARD;
        unit_phase = at_end ? PH_LEN_HI : PH_LEAD;
        cont_ok    = (data_byte[7:6] == 2'b10);
        unit_value = partial_unit_reg | {10'd0, data_byte[5:0]};
        fail_res   = '{code_unit: 16'd0, has_unit: 1'b0, last: 1'b1, malformed: 1'b1};

        phase_next        = phase_reg;
        length_high_next  = length_high_reg;
        bytes_left_next   = bytes_left_reg;
        partial_unit_next = partial_unit_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (step)
        begin
            unique case (phase_reg)
                PH_LEN_LO:
                begin
                    bytes_left_next = {length_high_reg, data_byte};
                    if ({length_high_reg, data_byte} == 16'd0)
                    begin
                        phase_next = PH_LEN_HI;
                        res_valid  = 1'b1;
                        res        = '{code_unit: 16'd0, has_unit: 1'b0, last: 1'b1,
                                       malformed: 1'b0};
                    end
                    else
                    begin
                        phase_next = PH_LEAD;
                    end
                end

                PH_LEAD:
                begin
                    bytes_left_next = bl_dec;
                    if (!data_byte[7])
                    begin
                        res_valid         = 1'b1;
                        partial_unit_next = '0;
                        if (data_byte == 8'd0)
                        begin
                            phase_next = fail_phase;
                            res        = fail_res;
                        end
                        else
                        begin
                            phase_next = unit_phase;
                            res        = '{code_unit: {8'd0, data_byte}, has_unit: 1'b1,
                                           last: at_end, malformed: 1'b0};
                        end
                    end
                    else if (data_byte[7:5] == 3'b110 && !at_end)
                    begin
                        partial_unit_next = {5'd0, data_byte[4:0], 6'd0};
                        phase_next        = PH_TWO_B2;
                    end
                    else if (data_byte[7:4] == 4'b1110 && bl_dec >= 16'd2)
                    begin
                        partial_unit_next = {data_byte[3:0], 12'd0};
                        phase_next        = PH_THREE_B2;
                    end
                    else
                    begin
                        // bad lead byte or truncated sequence
                        partial_unit_next = '0;
                        phase_next        = fail_phase;
                        res_valid         = 1'b1;
                        res               = fail_res;
                    end
                end

                PH_TWO_B2:
                begin
                    bytes_left_next   = bl_dec;
                    partial_unit_next = '0;
                    res_valid         = 1'b1;
                    if (!cont_ok || (unit_value < MIN_TWO_BYTE && unit_value != 16'd0))
                    begin
                        phase_next = fail_phase;
                        res        = fail_res;
                    end
                    else
                    begin
                        phase_next = unit_phase;
                        res        = '{code_unit: unit_value, has_unit: 1'b1,
                                       last: at_end, malformed: 1'b0};
                    end
                end

                PH_THREE_B2:
                begin
                    bytes_left_next = bl_dec;
                    if (!cont_ok || at_end)
                    begin
                        partial_unit_next = '0;
                        phase_next        = fail_phase;
                        res_valid         = 1'b1;
                        res               = fail_res;
                    end
                    else
                    begin
                        partial_unit_next = partial_unit_reg
                                            | {4'd0, data_byte[5:0], 6'd0};
                        phase_next        = PH_THREE_B3;
                    end
                end

                PH_THREE_B3:
                begin
                    bytes_left_next   = bl_dec;
                    partial_unit_next = '0;
                    res_valid         = 1'b1;
                    if (!cont_ok || unit_value < MIN_THREE_BYTE)
                    begin
                        phase_next = fail_phase;
                        res        = fail_res;
                    end
                    else
                    begin
                        phase_next = unit_phase;
                        res        = '{code_unit: unit_value, has_unit: 1'b1,
                                       last: at_end, malformed: 1'b0};
                    end
                end

                PH_DISCARD:
                begin
                    bytes_left_next = bl_dec;
                    if (at_end)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                end

                default:
                begin
                    // awaiting length high byte
                    length_high_next = data_byte;
                    phase_next       = PH_LEN_LO;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mu8d_out_reg.sv @@
// ----------------------------------------------------------------------------
// mu8d_out_reg
// Result register: holds one decoded result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mu8d_out_reg
    import mu8d_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire result_t  in_res,
    output logic          can_take,
    output logic          out_valid,
    input  wire logic     out_ready,
    output result_t       out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg,   res_next;

    assign can_take  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (in_valid && can_take)
        begin
            valid_next = 1'b1;
            res_next   = in_res;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/modified_utf8_string_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// modified_utf8_string_decoder_unit
// Decodes a stream of length-prefixed modified UTF-8 strings into UTF-16
// code units, one byte per cycle while the result channel is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis_*) carries raw bytes: two length bytes, high first,
//   then that many string body bytes, then the next string's length.
//   Master channel (m_axis_*) carries one request per completed code unit,
//   per empty string and per malformed string. tlast marks the final request
//   of a string; tuser says whether tdata holds a unit or the string failed.
//   Path: a taken byte passes the input register, one decode step and the
//   result register before its result shows.
//   Throughput: one byte per cycle while not stalled, bounded by the single
//   decode step between the input and result registers; multi-byte forms
//   give one result on their final byte only.
//   Reset: both registers empty, awaiting a length high byte.
//   Stall: while the result register is full and m_axis_tready is low, the
//   input register holds its byte and s_axis_tready drops once it is full.
//   On a malformed sequence one request with malformed set and tlast goes
//   out; the rest of the string is dropped silently. Units already sent for
//   that string stand, so the receiver discards the string.
// ----------------------------------------------------------------------------
`default_nettype none

module modified_utf8_string_decoder_unit
    import mu8d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] code_unit
    output logic             m_axis_tlast,   // last
    output logic [1:0]       m_axis_tuser    // [0] has_unit, [1] malformed
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg,  in_byte_next;

    logic       out_can_take;
    logic       step;
    logic       s_fire;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    // Advance the held byte whenever the result register can take whatever
    // it produces; bytes that give no result advance on the same condition.
    assign step          = in_valid_reg && out_can_take;
    assign s_axis_tready = !in_valid_reg || out_can_take;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = s_axis_tdata;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload register: no reset needed
    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
    end

    mu8d_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    mu8d_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_res    (res),
        .can_take  (out_can_take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.code_unit;
    assign m_axis_tlast = out_res.last;
    assign m_axis_tuser = {out_res.malformed, out_res.has_unit};

endmodule

`default_nettype wire

@@ hw/rtl/mu8d_checker.sv @@
// ----------------------------------------------------------------------------
// mu8d_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mu8d_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic [1:0]  m_axis_tuser
);

    // A malformed request always closes its string
    a_malformed_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
        else $error("malformed request without tlast or with a unit");

    // A request without a unit carries a zero code unit
    a_no_unit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
        else $error("non-unit request with nonzero tdata");

    // A request with no unit and no error is an empty string, so it ends it
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[1] |-> m_axis_tlast)
        else $error("empty-string request without tlast");

    // Hold a stalled request
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled request changed");

endmodule

bind modified_utf8_string_decoder_unit mu8d_checker u_mu8d_checker (.*);

`default_nettype wire

@@ sim/modified_utf8_string_decoder_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modified_utf8_string_decoder_unit_test
// Self-checking bench for the modified UTF-8 string decoder. Length-prefixed
// strings go in on the byte stream; each accepted byte also runs through a
// behavioural decoder here, and every unit it predicts is compared with the
// next request on the unit stream. Directed strings cover each form and each
// error, then random strings run with idle cycles on both sides, a burst
// without gaps and a long receiver hold-off.
// ----------------------------------------------------------------------------

module modified_utf8_string_decoder_unit_test;

    import mu8d_pkg::*;

    localparam int ITEM_TARGET = 640;      // bytes sent before the random test stops
    localparam int CYCLE_LIMIT = 200000;   // far above the slowest passing run
    localparam int IDLE_PERCENT = 23;
    localparam int DRAIN_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] data_byte

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [15:0] code_unit
    logic        m_axis_tlast;            // last
    logic [1:0]  m_axis_tuser;            // [0] has_unit, [1] malformed

    modified_utf8_string_decoder_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Decoder state mirrored by the bench
    phase_t      dec_phase = PH_LEN_HI;
    logic [7:0]  dec_len_high = 8'h00;
    logic [15:0] dec_bytes_left = 16'h0000;
    logic [15:0] dec_partial = 16'h0000;

    result_t     pending_units[$];
    logic [7:0]  string_body[$];

    int          mismatch_count = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          hold_request = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Give up if the run stalls; a passing run never gets near this
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Behavioural decoder: one call per accepted byte, queues what it yields
    // ------------------------------------------------------------------------
    function automatic void queue_unit(input logic [15:0] unit, input logic has,
                                       input logic fin, input logic bad);
        result_t r;
        r.code_unit = unit;
        r.has_unit  = has;
        r.last      = fin;
        r.malformed = bad;
        pending_units = {pending_units, r};
    endfunction

    // Malformed: one last request, then drop what is left of the string
    function automatic void decode_fail();
        dec_phase   = (dec_bytes_left == 16'h0000) ? PH_LEN_HI : PH_DISCARD;
        dec_partial = 16'h0000;
        queue_unit(16'h0000, 1'b0, 1'b1, 1'b1);
    endfunction

    function automatic void decode_unit(input logic [15:0] unit);
        logic fin;
        fin         = (dec_bytes_left == 16'h0000);
        dec_phase   = fin ? PH_LEN_HI : PH_LEAD;
        dec_partial = 16'h0000;
        queue_unit(unit, 1'b1, fin, 1'b0);
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        logic [15:0] v;
        case (dec_phase)
            PH_LEN_LO:
            begin
                dec_bytes_left = {dec_len_high, b};
                if (dec_bytes_left == 16'h0000)
                begin
                    // empty string: a bare last request with no unit
                    dec_phase = PH_LEN_HI;
                    queue_unit(16'h0000, 1'b0, 1'b1, 1'b0);
                end
                else
                    dec_phase = PH_LEAD;
            end
            PH_LEAD:
            begin
                dec_bytes_left = dec_bytes_left - 16'd1;
                if (b[7] == 1'b0)
                begin
                    if (b == 8'h00)
                        decode_fail();
                    else
                        decode_unit({8'h00, b});
                end
                else if (b[7:5] == 3'b110)
                begin
                    // a lead whose tail runs past the string fails at once
                    if (dec_bytes_left < 16'd1)
                        decode_fail();
                    else
                    begin
                        dec_partial = {5'b0, b[4:0], 6'b0};
                        dec_phase   = PH_TWO_B2;
                    end
                end
                else if (b[7:4] == 4'b1110)
                begin
                    if (dec_bytes_left < 16'd2)
                        decode_fail();
                    else
                    begin
                        dec_partial = {b[3:0], 12'b0};
                        dec_phase   = PH_THREE_B2;
                    end
                end
                else
                    decode_fail();
            end
            PH_TWO_B2:
            begin
                dec_bytes_left = dec_bytes_left - 16'd1;
                v = dec_partial | {10'b0, b[5:0]};
                if (b[7:6] != 2'b10)
                    decode_fail();
                else if (v < MIN_TWO_BYTE && v != 16'h0000)
                    decode_fail();
                else
                    decode_unit(v);
            end
            PH_THREE_B2:
            begin
                dec_bytes_left = dec_bytes_left - 16'd1;
                if (b[7:6] != 2'b10)
                    decode_fail();
                else
                begin
                    dec_partial = dec_partial | {4'b0, b[5:0], 6'b0};
                    if (dec_bytes_left == 16'h0000)
                        decode_fail();
                    else
                        dec_phase = PH_THREE_B3;
                end
            end
            PH_THREE_B3:
            begin
                dec_bytes_left = dec_bytes_left - 16'd1;
                v = dec_partial | {10'b0, b[5:0]};
                if (b[7:6] != 2'b10)
                    decode_fail();
                else if (v < MIN_THREE_BYTE)
                    decode_fail();
                else
                    decode_unit(v);
            end
            PH_DISCARD:
            begin
                dec_bytes_left = dec_bytes_left - 16'd1;
                if (dec_bytes_left == 16'h0000)
                    dec_phase = PH_LEN_HI;
            end
            default:
            begin
                dec_len_high = b;
                dec_phase    = PH_LEN_LO;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Byte sender: drive at the falling edge, accept at the rising edge
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        // hold the request until the decoder takes it
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_byte(b);
        bytes_sent++;
    endtask

    // Send string_body with its big-endian length in front
    task automatic send_string();
        logic [15:0] len;
        len = 16'(string_body.size());
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        foreach (string_body[i])
            send_byte(string_body[i]);
    endtask

    // ------------------------------------------------------------------------
    // String builders
    // ------------------------------------------------------------------------
    function automatic void append_unit(input logic [15:0] u);
        if (u != 16'h0000 && u <= 16'h007f)
            string_body = {string_body, u[7:0]};
        else if (u <= 16'h07ff)
        begin
            // U+0000 takes the two-byte form C0 80
            string_body = {string_body, {3'b110, u[10:6]}};
            string_body = {string_body, {2'b10, u[5:0]}};
        end
        else
        begin
            string_body = {string_body, {4'b1110, u[15:12]}};
            string_body = {string_body, {2'b10, u[11:6]}};
            string_body = {string_body, {2'b10, u[5:0]}};
        end
    endfunction

    function automatic logic [15:0] random_unit();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(1, 16'h007f));
            1:       return ($urandom_range(0, 9) == 0) ? 16'h0000
                            : 16'($urandom_range(16'h0080, 16'h07ff));
            default: return 16'($urandom_range(16'h0800, 16'hffff));
        endcase
    endfunction

    function automatic void build_clean_string(input int units);
        string_body.delete();
        repeat (units)
            append_unit(random_unit());
    endfunction

    // Mostly well-formed strings; the rest corrupted or pure noise
    function automatic void build_random_string();
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            build_clean_string($urandom_range(0, 8));
        else if (pick < 90)
        begin
            build_clean_string($urandom_range(1, 6));
            idx = $urandom_range(0, string_body.size() - 1);
            string_body[idx] = 8'($urandom);
            if ($urandom_range(0, 1) == 1)
                void'(string_body.pop_back());   // cut the tail short
        end
        else
        begin
            string_body.delete();
            repeat ($urandom_range(1, 6))
                string_body = {string_body, 8'($urandom)};
        end
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, plus a counted hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Compare every accepted request with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_units.size() == 0)
                report_error($sformatf("unexpected request: unit %h user %b last %b",
                                       m_axis_tdata, m_axis_tuser, m_axis_tlast));
            else
            begin
                want = pending_units.pop_front();
                if (m_axis_tdata !== want.code_unit)
                    report_error($sformatf("code_unit %h, expected %h",
                                           m_axis_tdata, want.code_unit));
                if (m_axis_tuser[0] !== want.has_unit)
                    report_error($sformatf("has_unit %b, expected %b",
                                           m_axis_tuser[0], want.has_unit));
                if (m_axis_tlast !== want.last)
                    report_error($sformatf("last %b, expected %b",
                                           m_axis_tlast, want.last));
                if (m_axis_tuser[1] !== want.malformed)
                    report_error($sformatf("malformed %b, expected %b",
                                           m_axis_tuser[1], want.malformed));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Each form at its limits, then every kind of malformed string
    task automatic test_directed();
        string_body.delete();
        send_string();                                    // empty string
        string_body = '{8'h41, 8'h7f, 8'hc0, 8'h80, 8'hdf, 8'hbf, 8'hc2, 8'h80,
                        8'he0, 8'ha0, 8'h80, 8'hef, 8'hbf, 8'hbf};
        send_string();                                    // all valid forms
        string_body = '{8'h00};
        send_string();                                    // raw zero byte
        string_body = '{8'h80, 8'h41};
        send_string();                                    // stray continuation as lead
        string_body = '{8'hff};
        send_string();                                    // lead above the three-byte range
        string_body = '{8'h41, 8'hc2};
        send_string();                                    // two-byte lead at string end
        string_body = '{8'he2, 8'h82};
        send_string();                                    // three-byte form cut short
        string_body = '{8'hc2, 8'h41};
        send_string();                                    // bad second byte
        string_body = '{8'he2, 8'h82, 8'h41, 8'h41, 8'h41};
        send_string();                                    // bad third byte, tail dropped
        string_body = '{8'hc1, 8'hbf};
        send_string();                                    // overlong two-byte form
        string_body = '{8'he0, 8'h9f, 8'hbf};
        send_string();                                    // overlong three-byte form
    endtask

    // No gaps on either side for a stretch
    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (6)
        begin
            build_clean_string($urandom_range(3, 8));
            send_string();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver holds off while bytes keep coming, so the input stalls
    task automatic test_receiver_hold();
        tx_idle_on   = 1'b0;
        hold_request = 80;
        build_clean_string(12);
        send_string();
        tx_idle_on   = 1'b1;
    endtask

    // A 256-byte body puts a non-zero high byte in the length prefix
    task automatic test_long_string();
        string_body.delete();
        while (string_body.size() < 253)
            append_unit(random_unit());
        while (string_body.size() < 256)
            string_body = {string_body, 8'($urandom_range(1, 16'h007f))};
        send_string();
    endtask

    task automatic test_random_strings();
        while (bytes_sent < ITEM_TARGET)
        begin
            build_random_string();
            send_string();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_back_to_back();
        test_receiver_hold();
        test_long_string();
        test_random_strings();

        // drop the request line, then drain what is still in flight
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
